FILE: rtl/fsba_pkg.sv
// Shared types and codes for the fit-strategy block allocator.
// Used by the channel interfaces and the allocator core; no dependencies.
package fsba_pkg;

  localparam int ACT_BITS   = 2;
  localparam int STAT_BITS  = 3;
  localparam int NUM_BITS   = 6;
  localparam int STRAT_BITS = 2;

  // Action codes of an input item.
  localparam logic [ACT_BITS-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_LIST  = 2'd2;

  // Fit strategy codes.
  localparam logic [STRAT_BITS-1:0] STRAT_NONE  = 2'd0;
  localparam logic [STRAT_BITS-1:0] STRAT_FIRST = 2'd1;
  localparam logic [STRAT_BITS-1:0] STRAT_BEST  = 2'd2;
  localparam logic [STRAT_BITS-1:0] STRAT_WORST = 2'd3;

  // Result status codes.
  localparam logic [STAT_BITS-1:0] ST_ADDED      = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_ALLOCATED  = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_UNSPLIT    = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_ALLOC  = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_TABLE_FULL = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_FREE_ENTRY = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_NO_FREE    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_LIST_END,
    S_DECIDE,
    S_SHIFT,
    S_W_REM,
    S_W_GRANT
  } state_t;

endpackage

FILE: rtl/fsba_req_if.sv
// Input channel of the block allocator: valid/ready handshake plus one item.
// Depends on fsba_pkg for field widths.
interface fsba_req_if #(
  parameter int SIZE_BITS = 24
);
  import fsba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_BITS-1:0]  action;
  logic [SIZE_BITS-1:0] item_size;

  modport source (output valid, output action, output item_size, input ready);
  modport sink   (input valid, input action, input item_size, output ready);
endinterface

FILE: rtl/fsba_rsp_if.sv
// Result channel of the block allocator: valid/ready handshake plus one item.
// Depends on fsba_pkg for field widths.
interface fsba_rsp_if #(
  parameter int SIZE_BITS = 24
);
  import fsba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_BITS-1:0] status;
  logic [NUM_BITS-1:0]  block_id;
  logic [SIZE_BITS-1:0] block_size;
  logic                 last_result;

  modport source (output valid, output status, output block_id, output block_size,
                  output last_result, input ready);
  modport sink   (input valid, input status, input block_id, input block_size,
                  input last_result, output ready);
endinterface

FILE: rtl/fsba_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies; holds the allocator's block table.
module fsba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fit_strategy_block_allocator_core.sv
// Fit-strategy block allocator: ordered block table with first, best and worst fit.
// Depends on fsba_pkg, fsba_req_if, fsba_rsp_if and fsba_ram.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+---------------------------------------------
//   req      | in        | valid/ready   | action, item_size
//   rsp      | out       | valid/ready   | status, block_id, block_size, last_result
//   cfg      | in        | cfg_we only   | cfg_data (fit strategy)
//
// An add writes one entry unless the table is full. An allocation scans the table through
// the single RAM read port with one subtract/compare unit; on a split it then moves the
// entries behind the chosen one down by one and writes two entries, else it writes only
// the granted entry. A listing scans the whole table and can be held by the result side.
// Reset clears the entry count, number counter and control flags and selects first
// fit; the table has no clearing pass, since entries at or beyond the count are never read.
// The next item is accepted while the last result still waits in the output register.
module fit_strategy_block_allocator_core #(
  parameter int MAX_BLOCKS = 32,
  parameter int SIZE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fsba_pkg::STRAT_BITS-1:0]   cfg_data,
  fsba_req_if.sink                          req,
  fsba_rsp_if.source                        rsp
);
  import fsba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = NUM_BITS + 1 + SIZE_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  state_t state, state_next;

  logic [STRAT_BITS-1:0] strategy;
  logic [ACT_BITS-1:0]   act;
  logic [SIZE_BITS-1:0]  req_size;
  logic [CNT_W-1:0]      count;
  logic [NUM_BITS-1:0]   next_num;

  logic [CNT_W-1:0]      rd_idx;
  logic                  chk_vld;
  logic [IDX_W-1:0]      chk_idx;

  logic                  pick_vld;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_BITS-1:0]  pick_size;
  logic [NUM_BITS-1:0]   pick_num;
  logic [SIZE_BITS-1:0]  best;
  logic                  split;

  logic                  pend_vld;
  logic [NUM_BITS-1:0]   pend_num;
  logic [SIZE_BITS-1:0]  pend_size;

  logic [CNT_W-1:0]      sh_src;
  logic                  wr_pend;
  logic [IDX_W-1:0]      wr_addr;

  logic                  out_valid;
  logic [STAT_BITS-1:0]  out_status;
  logic [NUM_BITS-1:0]   out_id;
  logic [SIZE_BITS-1:0]  out_size;
  logic                  out_last;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  logic                  in_ready;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [STAT_BITS-1:0]  ld_status;
  logic [NUM_BITS-1:0]   ld_id;
  logic [SIZE_BITS-1:0]  ld_size;
  logic                  ld_last;

  logic [SIZE_BITS-1:0]  e_size;
  logic                  e_free;
  logic [NUM_BITS-1:0]   e_num;
  logic                  borrow;
  logic [SIZE_BITS-1:0]  diff;
  logic                  fits;
  logic                  better;
  logic                  scan_more;
  logic                  scan_done;
  logic                  scan_adv;
  logic                  list_hit;
  logic                  sh_more;
  logic                  do_split;

  fsba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry layout: {number, free, size}.
  assign e_size = ram_rdata[SIZE_BITS-1:0];
  assign e_free = ram_rdata[SIZE_BITS];
  assign e_num  = ram_rdata[ENT_W-1 -: NUM_BITS];

  // The one shared subtract/compare unit of the scan.
  assign {borrow, diff} = {1'b0, e_size} - {1'b0, req_size};
  assign fits   = chk_vld && e_free && !borrow;
  assign better = !pick_vld || (strategy == STRAT_BEST && diff < best) ||
                  (strategy == STRAT_WORST && diff > best);

  assign scan_more = rd_idx < count;
  assign scan_done = !chk_vld && !scan_more;
  assign list_hit  = chk_vld && e_free;
  assign sh_more   = sh_src > CNT_W'(pick_idx);
  assign do_split  = (best != '0) && (count < CNT_MAX);

  assign out_free = !out_valid || rsp.ready;
  assign accept   = in_ready && req.valid;

  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.block_id    = out_id;
  assign rsp.block_size  = out_size;
  assign rsp.last_result = out_last;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.action)
            ACT_ADD:   state_next = S_ADD;
            ACT_ALLOC: state_next = (strategy == STRAT_NONE) ? S_DECIDE : S_SCAN;
            ACT_LIST:  state_next = S_SCAN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (act == ACT_ALLOC) begin
          if ((fits && strategy == STRAT_FIRST) || scan_done) state_next = S_DECIDE;
        end else if (scan_done) begin
          state_next = S_LIST_END;
        end
      end
      S_LIST_END: begin
        if (out_free) state_next = S_IDLE;
      end
      S_DECIDE: begin
        if (!pick_vld) begin
          if (out_free) state_next = S_IDLE;
        end else if (do_split) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_W_GRANT;
        end
      end
      S_SHIFT: begin
        if (!sh_more && !wr_pend) state_next = S_W_REM;
      end
      S_W_REM: begin
        state_next = S_W_GRANT;
      end
      S_W_GRANT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM ports, scan advance and result load.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    scan_adv  = 1'b0;
    out_load  = 1'b0;
    ld_status = ST_ADDED;
    ld_id     = '0;
    ld_size   = '0;
    ld_last   = 1'b1;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_ADD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count >= CNT_MAX) begin
            ld_status = ST_TABLE_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count[IDX_W-1:0];
            ram_wdata = {next_num, 1'b1, req_size};
            ld_status = ST_ADDED;
            ld_id     = next_num;
            ld_size   = req_size;
          end
        end
      end
      S_SCAN: begin
        // A listing holds the scan while a found entry cannot pass the held one.
        scan_adv  = !(act == ACT_LIST && list_hit && pend_vld && !out_free);
        ram_re    = scan_adv && scan_more;
        ram_raddr = rd_idx[IDX_W-1:0];
        if (act == ACT_LIST && list_hit && pend_vld && out_free) begin
          out_load  = 1'b1;
          ld_status = ST_FREE_ENTRY;
          ld_id     = pend_num;
          ld_size   = pend_size;
          ld_last   = 1'b0;
        end
      end
      S_LIST_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_vld) begin
            ld_status = ST_FREE_ENTRY;
            ld_id     = pend_num;
            ld_size   = pend_size;
          end else begin
            ld_status = ST_NO_FREE;
          end
        end
      end
      S_DECIDE: begin
        if (!pick_vld && out_free) begin
          out_load  = 1'b1;
          ld_status = ST_NOT_ALLOC;
        end
      end
      S_SHIFT: begin
        ram_re    = sh_more;
        ram_raddr = sh_src[IDX_W-1:0];
        if (wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr;
          ram_wdata = ram_rdata;
        end
      end
      S_W_REM: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx + IDX_W'(1);
        ram_wdata = {next_num, 1'b1, best};
      end
      S_W_GRANT: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = pick_idx;
          ram_wdata = {pick_num, 1'b0, split ? req_size : pick_size};
          out_load  = 1'b1;
          ld_status = (best != '0 && !split) ? ST_UNSPLIT : ST_ALLOCATED;
          ld_id     = pick_num;
          ld_size   = split ? req_size : pick_size;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strategy  <= STRAT_FIRST;
      count     <= '0;
      next_num  <= NUM_BITS'(1);
      chk_vld   <= 1'b0;
      pick_vld  <= 1'b0;
      pend_vld  <= 1'b0;
      split     <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        strategy <= cfg_data;
      end
      if (accept) begin
        chk_vld  <= 1'b0;
        pick_vld <= 1'b0;
        pend_vld <= 1'b0;
        split    <= 1'b0;
      end
      if (state == S_ADD && out_free && count < CNT_MAX) begin
        count    <= count + CNT_W'(1);
        next_num <= next_num + NUM_BITS'(1);
      end
      if (state == S_SCAN && scan_adv) begin
        chk_vld <= scan_more;
        if (act == ACT_ALLOC && fits && better) begin
          pick_vld <= 1'b1;
        end
        if (act == ACT_LIST && list_hit) begin
          pend_vld <= 1'b1;
        end
      end
      if (state == S_DECIDE) begin
        split   <= pick_vld && do_split;
        wr_pend <= 1'b0;
      end
      if (state == S_SHIFT) begin
        wr_pend <= sh_more;
      end
      if (state == S_W_REM) begin
        count    <= count + CNT_W'(1);
        next_num <= next_num + NUM_BITS'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= req.action;
      req_size <= req.item_size;
      rd_idx   <= '0;
    end
    if (state == S_SCAN && scan_adv) begin
      chk_idx <= rd_idx[IDX_W-1:0];
      if (scan_more) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (act == ACT_ALLOC && fits && better) begin
        pick_idx  <= chk_idx;
        pick_size <= e_size;
        pick_num  <= e_num;
        best      <= diff;
      end
      if (act == ACT_LIST && list_hit) begin
        pend_num  <= e_num;
        pend_size <= e_size;
      end
    end
    if (state == S_DECIDE) begin
      sh_src <= count - CNT_W'(1);
    end
    if (state == S_SHIFT && sh_more) begin
      wr_addr <= IDX_W'(sh_src + CNT_W'(1));
      sh_src  <= sh_src - CNT_W'(1);
    end
    if (out_load) begin
      out_status <= ld_status;
      out_id     <= ld_id;
      out_size   <= ld_size;
      out_last   <= ld_last;
    end
  end

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("entry count exceeds table depth");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten while held");

  // Moving entries down never touches the granted entry or its remainder slot.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && wr_pend) |-> (wr_addr > pick_idx + IDX_W'(1)))
    else $error("entry move writes below the insertion point");

endmodule
